// ===== sv/wwrf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wwrf_pkg
// Shared constants, types and helpers of the whole-word replace filter.
// ----------------------------------------------------------------------------
package wwrf_pkg;

	localparam int CHAR_W     = 8;
	localparam int MAX_WORD   = 16;
	localparam int WORD_CHARS = 16;
	localparam int NUM_CELLS  = (MAX_WORD > WORD_CHARS) ? MAX_WORD : WORD_CHARS;
	localparam int CNT_W      = $clog2(NUM_CELLS + 1);
	localparam int LEN_W      = 5;
	localparam int CMP_W      = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;

	localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LO  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_HI  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LEN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REPL_LO    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REPL_HI    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_REPL_LEN   = 3'd5;

	typedef struct packed {
		logic load;
		logic write;
		logic shift;
	} cell_ctrl_t;

	function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = c;
		if (c >= 8'd65 && c <= 8'd90) begin
			r = c + 8'd32;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/whole_word_replace_filter_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// whole_word_replace_filter_core
// Whole-word, case-insensitive find and replace on a byte stream.
// ----------------------------------------------------------------------------
// Bytes of a line enter on the s_ side; words are collected in a chain of
// byte cells and leave on the m_ side once a space or the line end resolves
// them, replaced when they match the search word. A buffered letter is
// written into the chain; a space or pass-through byte drains the chain
// through its head cell into the output register, one byte per cycle while
// the output is free, and then leaves itself. A line end after a letter
// passes a resolve state first; an empty replacement emits nothing. Output
// backpressure stretches the drain. Configuration must be written only while
// the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module whole_word_replace_filter_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [wwrf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [wwrf_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [7:0]                        s_tdata,   // [7:0] in_char
	input  wire logic                              s_tlast,   // line_end
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic      [7:0]                        m_tdata,   // [7:0] out_char
	output logic                                   m_tuser,   // run_last
	output logic                                   m_tlast    // line_done
);
	import wwrf_pkg::*;

	localparam logic [1:0] ST_ACCEPT  = 2'd0;
	localparam logic [1:0] ST_RESOLVE = 2'd1;
	localparam logic [1:0] ST_DRAIN   = 2'd2;

	logic [CFG_DATA_W-1:0] search_lo_q, search_hi_q, repl_lo_q, repl_hi_q;
	logic [LEN_W-1:0]      search_len_q, repl_len_q;

	logic [1:0]        state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic              pass_q, pass_d;
	logic [CHAR_W-1:0] extra_q, extra_d;
	logic              has_extra_q, has_extra_d;
	logic              last_q, last_d;

	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              out_run_last_q, out_line_done_q;

	logic [2*CFG_DATA_W-1:0] search_bytes, repl_bytes;
	logic [CHAR_W-1:0]       cell_char [NUM_CELLS];
	logic [NUM_CELLS-1:0]    cell_hit, below;
	cell_ctrl_t              cell_ctrl [NUM_CELLS];

	logic              load, shift, write_en, emit, emit_last;
	logic [CHAR_W-1:0] emit_char;
	logic              word_hit, slen_ok, out_free;
	logic [CNT_W-1:0]  repl_count;

	assign search_bytes = {search_hi_q, search_lo_q};
	assign repl_bytes   = {repl_hi_q, repl_lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_lo_q  <= '0;
			search_hi_q  <= '0;
			search_len_q <= LEN_W'(1);
			repl_lo_q    <= '0;
			repl_hi_q    <= '0;
			repl_len_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SEARCH_LO:  search_lo_q  <= cfg_data;
				CFG_SEARCH_HI:  search_hi_q  <= cfg_data;
				CFG_SEARCH_LEN: search_len_q <= cfg_data[LEN_W-1:0];
				CFG_REPL_LO:    repl_lo_q    <= cfg_data;
				CFG_REPL_HI:    repl_hi_q    <= cfg_data;
				CFG_REPL_LEN:   repl_len_q   <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		logic [CHAR_W-1:0] s_char, r_char, n_char;
		if (i < WORD_CHARS) begin : g_reg
			assign s_char = search_bytes[CHAR_W*i +: CHAR_W];
			assign r_char = repl_bytes[CHAR_W*i +: CHAR_W];
		end else begin : g_zero
			assign s_char = '0;
			assign r_char = '0;
		end
		if (i == NUM_CELLS - 1) begin : g_tail
			assign n_char = '0;
		end else begin : g_link
			assign n_char = cell_char[i+1];
		end
		assign below[i]           = (CNT_W'(i) < count_q);
		assign cell_ctrl[i].load  = load;
		assign cell_ctrl[i].shift = shift;
		assign cell_ctrl[i].write = write_en && (CNT_W'(i) == count_q);

		wwrf_cell u_cell (
			.clk          (clk),
			.ctrl         (cell_ctrl[i]),
			.in_char      (s_tdata),
			.search_char  (s_char),
			.replace_char (r_char),
			.next_char    (n_char),
			.char_out     (cell_char[i]),
			.hit          (cell_hit[i])
		);
	end

	assign slen_ok    = (search_len_q != '0) && (search_len_q <= LEN_W'(WORD_CHARS));
	assign word_hit   = (count_q != '0) && slen_ok
	                    && (CMP_W'(count_q) == CMP_W'(search_len_q))
	                    && (&(cell_hit | ~below));
	assign repl_count = (repl_len_q > LEN_W'(WORD_CHARS)) ? CNT_W'(WORD_CHARS)
	                                                      : CNT_W'(repl_len_q);
	assign out_free   = !out_valid_q || m_tready;
	assign s_tready   = (state_q == ST_ACCEPT);

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		pass_d      = pass_q;
		extra_d     = extra_q;
		has_extra_d = has_extra_q;
		last_d      = last_q;
		load        = 1'b0;
		shift       = 1'b0;
		write_en    = 1'b0;
		emit        = 1'b0;
		emit_last   = 1'b0;
		emit_char   = extra_q;
		unique case (state_q)
			ST_ACCEPT: begin
				if (s_tvalid) begin
					last_d = s_tlast;
					if (s_tdata == SPACE_CHAR) begin
						if (!pass_q && word_hit) begin
							load    = 1'b1;
							count_d = repl_count;
						end
						extra_d     = s_tdata;
						has_extra_d = 1'b1;
						pass_d      = 1'b0;
						state_d     = ST_DRAIN;
					end else if (pass_q || count_q >= CNT_W'(MAX_WORD)) begin
						extra_d     = s_tdata;
						has_extra_d = 1'b1;
						pass_d      = !s_tlast;
						state_d     = ST_DRAIN;
					end else begin
						write_en = 1'b1;
						count_d  = count_q + CNT_W'(1);
						if (s_tlast) begin
							state_d = ST_RESOLVE;
						end
					end
				end
			end
			ST_RESOLVE: begin
				if (word_hit) begin
					load    = 1'b1;
					count_d = repl_count;
				end
				has_extra_d = 1'b0;
				state_d     = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (count_q == '0 && !has_extra_q) begin
					state_d = ST_ACCEPT;
				end else if (out_free) begin
					emit = 1'b1;
					if (count_q != '0) begin
						emit_char = cell_char[0];
						shift     = 1'b1;
						count_d   = count_q - CNT_W'(1);
						emit_last = (count_q == CNT_W'(1)) && !has_extra_q;
					end else begin
						has_extra_d = 1'b0;
						emit_last   = 1'b1;
					end
					if (emit_last) begin
						state_d = ST_ACCEPT;
					end
				end
			end
			default: state_d = ST_ACCEPT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACCEPT;
			count_q     <= '0;
			pass_q      <= 1'b0;
			has_extra_q <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			pass_q      <= pass_d;
			has_extra_q <= has_extra_d;
			last_q      <= last_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		extra_q <= extra_d;
		if (emit) begin
			out_char_q      <= emit_char;
			out_run_last_q  <= emit_last;
			out_line_done_q <= emit_last && last_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_char_q;
	assign m_tuser  = out_run_last_q;
	assign m_tlast  = out_line_done_q;

endmodule
`default_nettype wire

// ===== sv/wwrf_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wwrf_cell
// One byte slot of the word chain: holds a byte and its case-folded match
// against the search byte of the same position; loads, captures or shifts.
// ----------------------------------------------------------------------------
module wwrf_cell (
	input  wire logic                      clk,
	input  wire wwrf_pkg::cell_ctrl_t      ctrl,
	input  wire logic [wwrf_pkg::CHAR_W-1:0] in_char,
	input  wire logic [wwrf_pkg::CHAR_W-1:0] search_char,
	input  wire logic [wwrf_pkg::CHAR_W-1:0] replace_char,
	input  wire logic [wwrf_pkg::CHAR_W-1:0] next_char,
	output logic      [wwrf_pkg::CHAR_W-1:0] char_out,
	output logic                           hit
);
	import wwrf_pkg::*;

	logic [CHAR_W-1:0] char_q;
	logic              hit_q;

	always_ff @(posedge clk) begin
		priority if (ctrl.load) begin
			char_q <= replace_char;
		end else if (ctrl.write) begin
			char_q <= in_char;
			hit_q  <= (fold_case(in_char) == fold_case(search_char));
		end else if (ctrl.shift) begin
			char_q <= next_char;
		end else begin
			char_q <= char_q;
		end
	end

	assign char_out = char_q;
	assign hit      = hit_q;

endmodule
`default_nettype wire
